@@ hw/rtl/framebuffer_line_draw_defines.svh @@
// Assertion macros for the line-draw engine.
// Depends on i_clk and i_rst_n being visible in the including module.
`ifndef FRAMEBUFFER_LINE_DRAW_DEFINES_SVH
`define FRAMEBUFFER_LINE_DRAW_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define FLD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define FLD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/fld_pkg.sv @@
// Shared types, codes and constants of the line-draw engine.
// No dependencies; used by every module of the block.
`default_nettype none

package fld_pkg;

    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 64;
    localparam int STORE_DEPTH   = 1024;
    localparam int ADDR_BITS     = $clog2(STORE_DEPTH);
    localparam int DATA_BITS     = 8;
    localparam int CNT_BITS      = 8;   // a line holds at most SCREEN_WIDTH on-screen points
    localparam int TOUCH_BITS    = 12;
    localparam logic [DATA_BITS-1:0] LEFT_BIT = 8'h80;

    typedef enum logic [1:0] {
        OP_LINE  = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        PEN_NONE   = 2'd0,
        PEN_CLEAR  = 2'd1,
        PEN_SET    = 2'd2,
        PEN_INVERT = 2'd3
    } t_pen;

    typedef enum logic [7:0] {
        S_INIT  = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_SETUP = 8'b0000_0100,
        S_ERR   = 8'b0000_1000,
        S_PLOT  = 8'b0001_0000,
        S_MOD   = 8'b0010_0000,
        S_READ  = 8'b0100_0000,
        S_CLEAR = 8'b1000_0000
    } t_state;

    typedef struct packed {
        logic on_screen;
        logic at_end;
    } t_step_flags;

    function automatic logic [DATA_BITS-1:0] apply_pen(
        input logic [DATA_BITS-1:0] data,
        input logic [DATA_BITS-1:0] mask,
        input t_pen                 pen
    );
        logic [DATA_BITS-1:0] res;
        case (pen)
            PEN_CLEAR: res = data & ~mask;
            PEN_SET:   res = data | mask;
            default:   res = data ^ mask;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/fld_frame_mem.sv @@
// Frame store: 1024 x 8 single-port-write, registered-read memory.
// Depends on fld_pkg for depth and widths.
`default_nettype none

module fld_frame_mem (
    input  wire logic                           i_clk,
    input  wire logic                           i_we,
    input  wire logic [fld_pkg::ADDR_BITS-1:0]  i_waddr,
    input  wire logic [fld_pkg::DATA_BITS-1:0]  i_wdata,
    input  wire logic [fld_pkg::ADDR_BITS-1:0]  i_raddr,
    output logic      [fld_pkg::DATA_BITS-1:0]  o_rdata
);

    logic [fld_pkg::DATA_BITS-1:0] r_mem [fld_pkg::STORE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ hw/rtl/fld_bres_step.sv @@
// Bresenham step unit: next point, error term, byte address and pixel mask.
// Depends on fld_pkg; shared by every point of a line walk.
`default_nettype none

module fld_bres_step #(
    parameter int COORD_BITS = 12
) (
    input  wire logic signed [COORD_BITS:0]   i_x,
    input  wire logic signed [COORD_BITS:0]   i_y,
    input  wire logic signed [COORD_BITS:0]   i_xe,
    input  wire logic signed [COORD_BITS:0]   i_ye,
    input  wire logic signed [COORD_BITS+2:0] i_err,
    input  wire logic        [COORD_BITS-1:0] i_dx,
    input  wire logic        [COORD_BITS-1:0] i_dy,
    input  wire logic                         i_x_dec,
    input  wire logic                         i_y_dec,
    output logic signed      [COORD_BITS:0]   o_x,
    output logic signed      [COORD_BITS:0]   o_y,
    output logic signed      [COORD_BITS+2:0] o_err,
    output logic             [fld_pkg::ADDR_BITS-1:0] o_addr,
    output logic             [fld_pkg::DATA_BITS-1:0] o_mask,
    output fld_pkg::t_step_flags              o_flags
);

    localparam int W = COORD_BITS + 1;
    localparam int E = COORD_BITS + 3;

    logic signed [E-1:0] dx_e;
    logic signed [E-1:0] dy_e;
    logic signed [E-1:0] err_px;
    logic                take_x;
    logic                take_y;

    assign dx_e   = $signed({{(E-COORD_BITS){1'b0}}, i_dx});
    assign dy_e   = $signed({{(E-COORD_BITS){1'b0}}, i_dy});
    assign err_px = i_err + dx_e;

    // err > -dx and err < dy
    assign take_x = (err_px > $signed(E'(0)));
    assign take_y = (i_err < dy_e);

    assign o_err = i_err - (take_x ? dy_e : $signed(E'(0)))
                         + (take_y ? dx_e : $signed(E'(0)));

    assign o_x = take_x ? (i_x_dec ? i_x - W'(1) : i_x + W'(1)) : i_x;
    assign o_y = take_y ? (i_y_dec ? i_y - W'(1) : i_y + W'(1)) : i_y;

    assign o_flags.on_screen = (i_x >= $signed(W'(0)))
                            && (i_x <  $signed(W'(fld_pkg::SCREEN_WIDTH)))
                            && (i_y >= $signed(W'(0)))
                            && (i_y <  $signed(W'(fld_pkg::SCREEN_HEIGHT)));
    assign o_flags.at_end = (i_x == i_xe) && (i_y == i_ye);

    // Split layout: row bits 4:0 pick the 32-byte line, row bit 5 the right half.
    assign o_addr = {i_y[4:0], i_y[5], i_x[6:3]};
    assign o_mask = fld_pkg::LEFT_BIT >> i_x[2:0];

endmodule

`default_nettype wire

@@ hw/rtl/framebuffer_line_draw.sv @@
// Line-draw engine over a 128x64 one-bit frame store in split layout.
// Depends on fld_pkg, fld_frame_mem, fld_bres_step and the defines header.
//
// Usage:
//   Command channel: a request is taken at a rising edge with start high and
//   busy low. opcode selects draw line, read frame byte or clear frame.
//   Result channel: o_done is high for exactly one cycle with o_read_data and
//   o_pixels_touched; the receiver must take it then, it cannot stall.
// Sequence:
//   Draw line: setup states SETUP and ERR, then for each drawn point a byte read in PLOT
//   and a modify and write in MOD through the one memory port, plus one on-screen check
//   in PLOT when the walk is cut short.
//   Read frame byte: address in IDLE, byte taken in READ. Clear frame: one byte a cycle.
//   Unused opcode: answered from IDLE with no work state.
//   The strobe comes in the cycle after the last work cycle; busy is already
//   low then, so the next request may be taken in that same cycle.
// Reset:
//   Synchronous, active low. After reset the engine sweeps all 1024 bytes to
//   zero, holding busy high throughout the sweep, and gives no result for it.
`default_nettype none

module framebuffer_line_draw #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   start,
    output logic                                        busy,
    input  wire logic [1:0]                             i_opcode,
    input  wire logic signed [COORD_BITS-1:0]           i_start_x,
    input  wire logic signed [COORD_BITS-1:0]           i_start_y,
    input  wire logic signed [COORD_BITS-1:0]           i_end_x,
    input  wire logic signed [COORD_BITS-1:0]           i_end_y,
    input  wire logic [1:0]                             i_pen_mode,
    input  wire logic [fld_pkg::ADDR_BITS-1:0]          i_read_address,
    output logic                                        o_done,
    output logic [fld_pkg::DATA_BITS-1:0]               o_read_data,
    output logic [fld_pkg::TOUCH_BITS-1:0]              o_pixels_touched
);

`include "framebuffer_line_draw_defines.svh"

    localparam int W = COORD_BITS + 1;
    localparam int E = COORD_BITS + 3;
    localparam int AB = fld_pkg::ADDR_BITS;
    localparam int DB = fld_pkg::DATA_BITS;
    localparam int CB = fld_pkg::CNT_BITS;

    fld_pkg::t_state        r_state, n_state;
    fld_pkg::t_pen          r_pen, n_pen;
    logic signed [W-1:0]    r_x, n_x, r_y, n_y, r_xe, n_xe, r_ye, n_ye;
    logic [COORD_BITS-1:0]  r_dx, n_dx, r_dy, n_dy;
    logic                   r_x_dec, n_x_dec, r_y_dec, n_y_dec;
    logic signed [E-1:0]    r_err, n_err;
    logic [CB-1:0]          r_count, n_count;
    logic [AB-1:0]          r_clr_cnt, n_clr_cnt;
    logic                   r_done, n_done;
    logic [DB-1:0]          r_read_data, n_read_data;
    logic [CB-1:0]          r_pixels, n_pixels;

    logic                   mem_we;
    logic [AB-1:0]          mem_waddr, mem_raddr;
    logic [DB-1:0]          mem_wdata, mem_rdata;

    logic signed [W-1:0]    step_x, step_y;
    logic signed [E-1:0]    step_err;
    logic [AB-1:0]          step_addr;
    logic [DB-1:0]          step_mask;
    fld_pkg::t_step_flags   step_flags;

    logic signed [W-1:0]    diff_x, diff_y;
    logic signed [W-1:0]    abs_x, abs_y;

    fld_frame_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    fld_bres_step #(
        .COORD_BITS (COORD_BITS)
    ) u_step (
        .i_x     (r_x),
        .i_y     (r_y),
        .i_xe    (r_xe),
        .i_ye    (r_ye),
        .i_err   (r_err),
        .i_dx    (r_dx),
        .i_dy    (r_dy),
        .i_x_dec (r_x_dec),
        .i_y_dec (r_y_dec),
        .o_x     (step_x),
        .o_y     (step_y),
        .o_err   (step_err),
        .o_addr  (step_addr),
        .o_mask  (step_mask),
        .o_flags (step_flags)
    );

    assign diff_x = r_xe - r_x;
    assign diff_y = r_ye - r_y;
    assign abs_x  = diff_x[W-1] ? -diff_x : diff_x;
    assign abs_y  = diff_y[W-1] ? -diff_y : diff_y;

    always_comb begin
        n_state     = r_state;
        n_pen       = r_pen;
        n_x         = r_x;
        n_y         = r_y;
        n_xe        = r_xe;
        n_ye        = r_ye;
        n_dx        = r_dx;
        n_dy        = r_dy;
        n_x_dec     = r_x_dec;
        n_y_dec     = r_y_dec;
        n_err       = r_err;
        n_count     = r_count;
        n_clr_cnt   = r_clr_cnt;
        n_done      = 1'b0;
        n_read_data = r_read_data;
        n_pixels    = r_pixels;
        mem_we      = 1'b0;
        mem_waddr   = step_addr;
        mem_wdata   = '0;
        mem_raddr   = (r_state == fld_pkg::S_IDLE) ? i_read_address : step_addr;

        case (r_state)
            fld_pkg::S_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_cnt;
                n_clr_cnt = r_clr_cnt + AB'(1);
                if (r_clr_cnt == AB'(fld_pkg::STORE_DEPTH - 1)) begin
                    n_state = fld_pkg::S_IDLE;
                end
            end
            fld_pkg::S_IDLE: begin
                if (start) begin
                    case (fld_pkg::t_opcode'(i_opcode))
                        fld_pkg::OP_LINE: begin
                            n_x     = {i_start_x[COORD_BITS-1], i_start_x};
                            n_y     = {i_start_y[COORD_BITS-1], i_start_y};
                            n_xe    = {i_end_x[COORD_BITS-1], i_end_x};
                            n_ye    = {i_end_y[COORD_BITS-1], i_end_y};
                            n_pen   = fld_pkg::t_pen'(i_pen_mode);
                            n_count = '0;
                            n_state = fld_pkg::S_SETUP;
                        end
                        fld_pkg::OP_READ: begin
                            n_state = fld_pkg::S_READ;
                        end
                        fld_pkg::OP_CLEAR: begin
                            n_clr_cnt = '0;
                            n_state   = fld_pkg::S_CLEAR;
                        end
                        default: begin
                            n_done      = 1'b1;
                            n_read_data = '0;
                            n_pixels    = '0;
                        end
                    endcase
                end
            end
            fld_pkg::S_SETUP: begin
                n_dx    = abs_x[COORD_BITS-1:0];
                n_dy    = abs_y[COORD_BITS-1:0];
                // step down when start is not below end
                n_x_dec = !(diff_x > $signed(W'(0)));
                n_y_dec = !(diff_y > $signed(W'(0)));
                n_state = fld_pkg::S_ERR;
            end
            fld_pkg::S_ERR: begin
                n_err   = (r_dx > r_dy) ? $signed(E'(r_dx >> 1)) : -$signed(E'(r_dy >> 1));
                n_state = fld_pkg::S_PLOT;
            end
            fld_pkg::S_PLOT: begin
                // read the target byte here; drop the walk when off-screen or no pen
                if (step_flags.on_screen && (r_pen != fld_pkg::PEN_NONE)) begin
                    n_state = fld_pkg::S_MOD;
                end else begin
                    n_done      = 1'b1;
                    n_read_data = '0;
                    n_pixels    = r_count;
                    n_state     = fld_pkg::S_IDLE;
                end
            end
            fld_pkg::S_MOD: begin
                mem_we    = 1'b1;
                mem_wdata = fld_pkg::apply_pen(mem_rdata, step_mask, r_pen);
                n_count   = r_count + CB'(1);
                if (step_flags.at_end) begin
                    n_done      = 1'b1;
                    n_read_data = '0;
                    n_pixels    = r_count + CB'(1);
                    n_state     = fld_pkg::S_IDLE;
                end else begin
                    n_x     = step_x;
                    n_y     = step_y;
                    n_err   = step_err;
                    n_state = fld_pkg::S_PLOT;
                end
            end
            fld_pkg::S_READ: begin
                n_done      = 1'b1;
                n_read_data = mem_rdata;
                n_pixels    = '0;
                n_state     = fld_pkg::S_IDLE;
            end
            fld_pkg::S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_cnt;
                n_clr_cnt = r_clr_cnt + AB'(1);
                if (r_clr_cnt == AB'(fld_pkg::STORE_DEPTH - 1)) begin
                    n_done      = 1'b1;
                    n_read_data = '0;
                    n_pixels    = '0;
                    n_state     = fld_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fld_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= fld_pkg::S_INIT;
            r_clr_cnt <= '0;
            r_count   <= '0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_cnt <= n_clr_cnt;
            r_count   <= n_count;
            r_done    <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pen       <= n_pen;
        r_x         <= n_x;
        r_y         <= n_y;
        r_xe        <= n_xe;
        r_ye        <= n_ye;
        r_dx        <= n_dx;
        r_dy        <= n_dy;
        r_x_dec     <= n_x_dec;
        r_y_dec     <= n_y_dec;
        r_err       <= n_err;
        r_read_data <= n_read_data;
        r_pixels    <= n_pixels;
    end

    assign busy             = (r_state != fld_pkg::S_IDLE);
    assign o_done           = r_done;
    assign o_read_data      = r_read_data;
    assign o_pixels_touched = fld_pkg::TOUCH_BITS'(r_pixels);

    `FLD_ASSERT_NOW(a_done_in_idle, o_done, r_state == fld_pkg::S_IDLE,
        "result strobe outside idle")
    `FLD_ASSERT_NEXT(a_line_goes_busy,
        start && !busy && i_opcode == fld_pkg::OP_LINE, busy,
        "line request did not start a walk")
    `FLD_ASSERT_NOW(a_write_states, mem_we,
        r_state == fld_pkg::S_MOD || r_state == fld_pkg::S_CLEAR
            || r_state == fld_pkg::S_INIT,
        "frame write outside a write state")
    `FLD_ASSERT_NOW(a_count_bound, r_state == fld_pkg::S_PLOT,
        r_count <= CB'(fld_pkg::SCREEN_WIDTH), "point count beyond screen width")

endmodule

`default_nettype wire

@@ tb/framebuffer_line_draw_tb.sv @@
// Testbench for framebuffer_line_draw: directed and random requests, each checked
// against a behavioral copy of the 128x64 split-layout frame store.
// Depends on fld_pkg and the framebuffer_line_draw RTL.
`timescale 1ns / 100ps

module framebuffer_line_draw_tb;
    import fld_pkg::*;

    localparam int COORD_BITS    = 12;
    localparam int STALL_LIMIT   = 5000;
    localparam int DRAIN_CYCLES  = 300;
    localparam int RANDOM_ITEMS  = 1050;

    typedef struct {
        t_opcode                opcode;
        logic signed [11:0]     start_x;
        logic signed [11:0]     start_y;
        logic signed [11:0]     end_x;
        logic signed [11:0]     end_y;
        t_pen                   pen;
        logic [ADDR_BITS-1:0]   read_address;
    } request_t;

    typedef struct {
        logic [DATA_BITS-1:0]   read_data;
        logic [TOUCH_BITS-1:0]  pixels_touched;
    } reply_t;

    class frame_scoreboard;
        logic [DATA_BITS-1:0] frame_bytes [STORE_DEPTH];
        reply_t               pending_replies [$];
        int                   errors;

        function new();
            wipe_frame();
            errors = 0;
        endfunction

        function void wipe_frame();
            foreach (frame_bytes[i]) frame_bytes[i] = '0;
        endfunction

        // Lower half-rows sit in the right 16 bytes of each 32-byte row.
        function int pixel_index(int x, int y);
            if (y >= 32)
                return 16 + (y - 32) * 32 + x / 8;
            return y * 32 + x / 8;
        endfunction

        function bit paint_pixel(int x, int y, t_pen pen);
            int                   idx;
            logic [DATA_BITS-1:0] mask;
            if (pen == PEN_NONE || x < 0 || x >= SCREEN_WIDTH || y < 0 || y >= SCREEN_HEIGHT)
                return 1'b0;
            idx  = pixel_index(x, y);
            mask = LEFT_BIT >> (x & 7);
            case (pen)
                PEN_CLEAR: frame_bytes[idx] = frame_bytes[idx] & ~mask;
                PEN_SET:   frame_bytes[idx] = frame_bytes[idx] | mask;
                default:   frame_bytes[idx] = frame_bytes[idx] ^ mask;
            endcase
            return 1'b1;
        endfunction

        function int walk_line(int x, int y, int xe, int ye, t_pen pen);
            int dx, dy, sx, sy, err, e2, count;
            dx    = (xe > x) ? xe - x : x - xe;
            dy    = (ye > y) ? ye - y : y - ye;
            sx    = (x < xe) ? 1 : -1;
            sy    = (y < ye) ? 1 : -1;
            err   = (dx > dy) ? dx / 2 : -(dy / 2);
            count = 0;
            // Stop at the first point that cannot be painted.
            while (paint_pixel(x, y, pen)) begin
                count++;
                if (x == xe && y == ye)
                    break;
                e2 = err;
                if (e2 > -dx) begin
                    err -= dy;
                    x   += sx;
                end
                if (e2 < dy) begin
                    err += dx;
                    y   += sy;
                end
            end
            return count;
        endfunction

        function void note_request(request_t req);
            reply_t rep;
            rep.read_data      = '0;
            rep.pixels_touched = '0;
            case (req.opcode)
                OP_LINE:  rep.pixels_touched = TOUCH_BITS'(walk_line(req.start_x, req.start_y,
                                                   req.end_x, req.end_y, req.pen));
                OP_READ:  rep.read_data = frame_bytes[req.read_address];
                OP_CLEAR: wipe_frame();
                default: ;
            endcase
            pending_replies.push_back(rep);
        endfunction

        function void check_result(logic [DATA_BITS-1:0] rd, logic [TOUCH_BITS-1:0] touched);
            reply_t exp;
            if (pending_replies.size() == 0) begin
                errors++;
                $display("%0t: result with no request waiting: read_data %02h pixels_touched %0d",
                         $time, rd, touched);
                return;
            end
            exp = pending_replies.pop_front();
            if (rd !== exp.read_data) begin
                errors++;
                $display("%0t: read_data expected %02h actual %02h", $time, exp.read_data, rd);
            end
            if (touched !== exp.pixels_touched) begin
                errors++;
                $display("%0t: pixels_touched expected %0d actual %0d",
                         $time, exp.pixels_touched, touched);
            end
        endfunction
    endclass

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           start;
    logic                           busy;
    logic [1:0]                     i_opcode;
    logic signed [COORD_BITS-1:0]   i_start_x;
    logic signed [COORD_BITS-1:0]   i_start_y;
    logic signed [COORD_BITS-1:0]   i_end_x;
    logic signed [COORD_BITS-1:0]   i_end_y;
    logic [1:0]                     i_pen_mode;
    logic [ADDR_BITS-1:0]           i_read_address;
    logic                           o_done;
    logic [DATA_BITS-1:0]           o_read_data;
    logic [TOUCH_BITS-1:0]          o_pixels_touched;

    frame_scoreboard sb = new();
    int              stall_cycles;

    framebuffer_line_draw #(
        .COORD_BITS(COORD_BITS)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_opcode(i_opcode),
        .i_start_x(i_start_x),
        .i_start_y(i_start_y),
        .i_end_x(i_end_x),
        .i_end_y(i_end_y),
        .i_pen_mode(i_pen_mode),
        .i_read_address(i_read_address),
        .o_done(o_done),
        .o_read_data(o_read_data),
        .o_pixels_touched(o_pixels_touched)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_done === 1'b1)
            sb.check_result(o_read_data, o_pixels_touched);
    end

    // End the run when neither side has moved for too long.
    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_done === 1'b1) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic int wild_coord();
        logic signed [11:0] c;
        c = 12'($urandom);
        return c;
    endfunction

    function automatic request_t mk_line(int x0, int y0, int x1, int y1, t_pen pen);
        request_t req;
        req.opcode       = OP_LINE;
        req.start_x      = 12'(x0);
        req.start_y      = 12'(y0);
        req.end_x        = 12'(x1);
        req.end_y        = 12'(y1);
        req.pen          = pen;
        req.read_address = ADDR_BITS'($urandom);
        return req;
    endfunction

    // Fill the fields that the opcode ignores with noise.
    function automatic request_t mk_op(t_opcode op, int addr);
        request_t req;
        req              = mk_line(wild_coord(), wild_coord(), wild_coord(), wild_coord(),
                                   t_pen'(2'($urandom)));
        req.opcode       = op;
        req.read_address = ADDR_BITS'(addr);
        return req;
    endfunction

    task automatic send_request(input request_t req, input bit may_idle);
        while (may_idle && $urandom_range(99) < 21) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        i_opcode       <= req.opcode;
        i_start_x      <= req.start_x;
        i_start_y      <= req.start_y;
        i_end_x        <= req.end_x;
        i_end_y        <= req.end_y;
        i_pen_mode     <= req.pen;
        i_read_address <= req.read_address;
        start          <= 1'b1;
        @(posedge i_clk);
        while (busy !== 1'b0)
            @(posedge i_clk);
        sb.note_request(req);
        @(negedge i_clk);
    endtask

    initial begin
        int       roll;
        int       last_x;
        int       last_y;
        request_t req;

        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_opcode       = OP_NONE;
        i_start_x      = '0;
        i_start_y      = '0;
        i_end_x        = '0;
        i_end_y        = '0;
        i_pen_mode     = PEN_NONE;
        i_read_address = '0;
        stall_cycles   = 0;
        last_x         = 0;
        last_y         = 0;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: corners, both octant kinds, pens, off-screen starts and exits.
        send_request(mk_op(OP_READ, 0), 1'b1);
        send_request(mk_line(0, 0, 127, 63, PEN_SET), 1'b1);
        send_request(mk_op(OP_READ, 0), 1'b1);
        send_request(mk_op(OP_READ, 1023), 1'b1);
        send_request(mk_line(127, 0, 0, 63, PEN_INVERT), 1'b1);
        send_request(mk_line(5, 0, 9, 63, PEN_SET), 1'b1);
        send_request(mk_line(0, 31, 127, 31, PEN_SET), 1'b1);
        send_request(mk_line(64, 0, 64, 63, PEN_INVERT), 1'b1);
        send_request(mk_line(127, 63, 127, 63, PEN_SET), 1'b1);
        send_request(mk_line(0, 0, 100, 20, PEN_NONE), 1'b1);
        send_request(mk_line(-1, 5, 10, 5, PEN_SET), 1'b1);
        send_request(mk_line(128, 0, 0, 0, PEN_SET), 1'b1);
        send_request(mk_line(0, 64, 0, 0, PEN_SET), 1'b1);
        send_request(mk_line(-2048, -2048, 2047, 2047, PEN_INVERT), 1'b1);
        send_request(mk_line(2047, 2047, 0, 0, PEN_SET), 1'b1);
        send_request(mk_line(120, 10, 2047, 10, PEN_SET), 1'b1);
        send_request(mk_line(3, 60, -2048, -2048, PEN_INVERT), 1'b1);
        send_request(mk_line(10, 10, 10, -5, PEN_CLEAR), 1'b1);
        send_request(mk_op(OP_NONE, 1023), 1'b1);
        send_request(mk_op(OP_READ, 16), 1'b1);
        send_request(mk_op(OP_READ, 511), 1'b1);
        send_request(mk_op(OP_READ, 1008), 1'b1);
        send_request(mk_op(OP_CLEAR, 0), 1'b1);
        send_request(mk_op(OP_READ, 0), 1'b1);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            roll = $urandom_range(99);
            if (roll < 65) begin
                last_x = $urandom_range(SCREEN_WIDTH - 1);
                last_y = $urandom_range(SCREEN_HEIGHT - 1);
            end
            if (roll < 55)
                req = mk_line(last_x, last_y, $urandom_range(SCREEN_WIDTH - 1),
                              $urandom_range(SCREEN_HEIGHT - 1), t_pen'(2'($urandom)));
            else if (roll < 65)
                req = mk_line(last_x, last_y, wild_coord(), wild_coord(), t_pen'(2'($urandom)));
            else if (roll < 70)
                req = mk_line(wild_coord(), wild_coord(), wild_coord(), wild_coord(),
                              t_pen'(2'($urandom)));
            else if (roll < 84)
                req = mk_op(OP_READ, sb.pixel_index(last_x, last_y));
            else if (roll < 97)
                req = mk_op(OP_READ, $urandom_range(STORE_DEPTH - 1));
            else if (roll < 99)
                req = mk_op(OP_NONE, $urandom_range(STORE_DEPTH - 1));
            else
                req = mk_op(OP_CLEAR, $urandom_range(STORE_DEPTH - 1));
            // Hold start high, with no idle gaps, for requests 400 to 599.
            send_request(req, !(n >= 400 && n < 600));
        end

        start <= 1'b0;
        while (sb.pending_replies.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending_replies.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
